/* sv/iafp_pkg.sv */
// shared types and constants for the imu angle frame parser
package iafp_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 11;
  localparam logic [7:0]  HDR_FIRST   = 8'h55;
  localparam logic [7:0]  HDR_SECOND  = 8'h53;
  localparam logic [3:0]  YAW_LO_IDX  = 4'd6;
  localparam logic [3:0]  YAW_HI_IDX  = 4'd7;
  localparam logic [3:0]  LAST_IDX    = 4'(FRAME_BYTES - 1);

  // raw * 180 / 128 reduces to raw * 45 / 32
  localparam int unsigned YAW_MUL     = 45;
  localparam int unsigned YAW_SHIFT   = 5;
  localparam int unsigned PROD_W      = 22;

  // field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned DEG_W       = 17;

  // parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR1 = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // registered byte handed from the input stage to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_beat_t;

endpackage

/* sv/iafp_in_if.sv */
// byte input channel
interface iafp_in_if;
  logic                           valid;
  logic                           ready;
  logic [iafp_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/iafp_out_if.sv */
// frame result channel
interface iafp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           frame_ok;
  logic [iafp_pkg::RAW_W-1:0]     yaw_raw;
  logic [iafp_pkg::DEG_W-1:0]     yaw_deg_q8;

  modport source (output valid, output frame_ok, output yaw_raw, output yaw_deg_q8,
                  input ready);
  modport sink   (input valid, input frame_ok, input yaw_raw, input yaw_deg_q8,
                  output ready);
endinterface

/* sv/iafp_in_stage.sv */
// input register for received bytes
module iafp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  iafp_in_if.sink              in_ch,
  input  logic                 take,
  output iafp_pkg::byte_beat_t beat
);

  logic                        valid_r;
  logic [iafp_pkg::BYTE_W-1:0] data_r;

  // room whenever empty or drained this cycle
  assign in_ch.ready = !valid_r || take;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // byte capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.rx_byte;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule

/* sv/iafp_parser.sv */
// frame tracking, checksum, yaw scaling and result register
module iafp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iafp_pkg::byte_beat_t beat,
  output logic                 take,
  iafp_out_if.source           out_ch
);

  iafp_pkg::phase_t            phase_r, phase_nxt;
  logic [3:0]                  count_r, count_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [7:0]                  yaw_lo_r, yaw_lo_nxt;
  logic [7:0]                  yaw_hi_r, yaw_hi_nxt;

  logic                        out_valid_r;
  logic                        ok_r;
  logic [iafp_pkg::RAW_W-1:0]  raw_r;
  logic [iafp_pkg::DEG_W-1:0]  deg_r;

  logic                        emit;
  logic                        ok;
  logic [iafp_pkg::RAW_W-1:0]  raw;
  logic [iafp_pkg::PROD_W-1:0] prod;
  logic [iafp_pkg::DEG_W-1:0]  deg;

  // advance when a byte waits and the result slot is free or draining
  assign take = beat.valid && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    yaw_lo_nxt = yaw_lo_r;
    yaw_hi_nxt = yaw_hi_r;
    if (take) begin
      case (phase_r)
        iafp_pkg::PH_HUNT: begin
          if (beat.data == iafp_pkg::HDR_FIRST) begin
            phase_nxt = iafp_pkg::PH_HDR1;
            count_nxt = 4'd1;
            sum_nxt   = beat.data;
          end
        end
        iafp_pkg::PH_HDR1: begin
          if (beat.data == iafp_pkg::HDR_SECOND) begin
            phase_nxt = iafp_pkg::PH_BODY;
            count_nxt = 4'd2;
            sum_nxt   = sum_r + beat.data;
          end else begin
            phase_nxt = iafp_pkg::PH_HUNT;
            count_nxt = 4'd0;
            sum_nxt   = 8'd0;
          end
        end
        iafp_pkg::PH_BODY: begin
          if (count_r >= iafp_pkg::LAST_IDX) begin
            phase_nxt = iafp_pkg::PH_HUNT;
            count_nxt = 4'd0;
            sum_nxt   = 8'd0;
          end else begin
            if (count_r == iafp_pkg::YAW_LO_IDX) begin
              yaw_lo_nxt = beat.data;
            end else if (count_r == iafp_pkg::YAW_HI_IDX) begin
              yaw_hi_nxt = beat.data;
            end
            sum_nxt   = sum_r + beat.data;
            count_nxt = count_r + 4'd1;
          end
        end
        default: begin
          phase_nxt = iafp_pkg::PH_HUNT;
          count_nxt = 4'd0;
          sum_nxt   = 8'd0;
        end
      endcase
    end
  end

  // result of the checksum byte
  always_comb begin
    emit = take && (phase_r == iafp_pkg::PH_BODY) && (count_r >= iafp_pkg::LAST_IDX);
    ok   = (sum_r == beat.data);
    raw  = {yaw_hi_r, yaw_lo_r};
    prod = iafp_pkg::PROD_W'(raw) * iafp_pkg::PROD_W'(iafp_pkg::YAW_MUL);
    deg  = prod[iafp_pkg::YAW_SHIFT +: iafp_pkg::DEG_W];
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= iafp_pkg::PH_HUNT;
      count_r  <= 4'd0;
      sum_r    <= 8'd0;
      yaw_lo_r <= 8'd0;
      yaw_hi_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      yaw_lo_r <= yaw_lo_nxt;
      yaw_hi_r <= yaw_hi_nxt;
    end
  end

  // result slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, yaw zeroed on a bad checksum
  always_ff @(posedge clk) begin
    if (emit) begin
      ok_r  <= ok;
      raw_r <= ok ? raw : '0;
      deg_r <= ok ? deg : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_ok   = ok_r;
  assign out_ch.yaw_raw    = raw_r;
  assign out_ch.yaw_deg_q8 = deg_r;

endmodule

/* sv/imu_angle_frame_parser.sv */
// top level of the imu angle frame parser
//
// in_ch carries one received serial byte per beat. The parser hunts for the
// header 0x55 0x53, collects the rest of an 11-byte angle frame with an 8-bit
// running sum of bytes 0..9, and on the checksum byte puts one beat on out_ch:
// frame_ok, the raw yaw word from bytes 6 and 7, and yaw in degrees as
// unsigned Q8 (raw * 180 / 128, truncated). A bad checksum still gives a beat,
// with frame_ok low and both yaw fields zero; other bytes give no beat.
// Throughput is one byte per cycle while out_ch is not stalled: an input register
// feeds the parser, whose state update and 16x6 yaw multiply are combinational
// ahead of the result register, which is loaded when the checksum byte is taken.
// When out_ch stalls with a result pending, the parser holds and the input
// register absorbs one more byte before in_ch.ready drops.
// Synchronous reset (rst_n low) empties both registers and returns the
// parser to hunting with sum and yaw bytes cleared.
module imu_angle_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  iafp_in_if.sink    in_ch,
  iafp_out_if.source out_ch
);

  iafp_pkg::byte_beat_t beat;
  logic                 take;

  // input register
  iafp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .beat  (beat)
  );

  // parser and result register
  iafp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .take   (take),
    .out_ch (out_ch)
  );

  // a failed frame never reports yaw
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_ok |-> out_ch.yaw_raw == '0 && out_ch.yaw_deg_q8 == '0)
    else $error("bad frame carries yaw");

  // parser must hold while a result is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !take)
    else $error("parser advanced into a stalled result");

  // backpressure only with a byte waiting in the input register
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> beat.valid)
    else $error("input ready low with empty register");

  // a stalled byte is kept for the parser
  a_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid && !take |=> beat.valid && $stable(beat.data))
    else $error("pending byte lost");

endmodule

/* sim/imu_angle_frame_parser_test.sv */
// testbench for the imu angle frame parser: byte stream in, checked angle frames out
`timescale 1ns / 1ps

module imu_angle_frame_parser_test;

  // expected angle frame result
  typedef struct packed {
    logic                       ok;
    logic [iafp_pkg::RAW_W-1:0] raw;
    logic [iafp_pkg::DEG_W-1:0] deg;
  } angle_res_t;

  logic clk;
  logic rst_n;

  iafp_in_if  in_ch();
  iafp_out_if out_ch();

  imu_angle_frame_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser tracking state
  iafp_pkg::phase_t hunt_phase;
  logic [3:0]       hunt_count;
  logic [7:0]       frame_sum;
  logic [7:0]       yaw_lo_byte;
  logic [7:0]       yaw_hi_byte;
  angle_res_t       pending_angles[$];

  // run control and statistics
  int mismatches      = 0;
  int bytes_sent      = 0;
  int good_frames     = 0;
  int bad_frames      = 0;
  int in_stall_cycles = 0;
  int rx_hold_req     = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // back to header hunting
  function automatic void restart_hunt();
    hunt_phase = iafp_pkg::PH_HUNT;
    hunt_count = '0;
    frame_sum  = '0;
  endfunction

  // advance the tracked parser by one accepted byte, queue a frame result if one ends
  task automatic parse_rx_byte(input logic [7:0] b);
    angle_res_t                 res;
    logic [iafp_pkg::RAW_W-1:0] raw;
    logic [31:0]                prod;
    case (hunt_phase)
      iafp_pkg::PH_HUNT: begin
        if (b == iafp_pkg::HDR_FIRST) begin
          hunt_phase = iafp_pkg::PH_HDR1;
          hunt_count = 4'd1;
          frame_sum  = b;
        end
      end
      iafp_pkg::PH_HDR1: begin
        if (b == iafp_pkg::HDR_SECOND) begin
          hunt_phase = iafp_pkg::PH_BODY;
          hunt_count = 4'd2;
          frame_sum  = frame_sum + b;
        end else begin
          restart_hunt();
        end
      end
      iafp_pkg::PH_BODY: begin
        if (hunt_count >= iafp_pkg::LAST_IDX) begin
          raw  = {yaw_hi_byte, yaw_lo_byte};
          prod = 32'(raw) * 32'd180;
          res.ok  = (frame_sum == b);
          res.raw = res.ok ? raw : '0;
          res.deg = res.ok ? iafp_pkg::DEG_W'(prod >> 7) : '0;
          pending_angles.push_back(res);
          restart_hunt();
        end else begin
          if (hunt_count == iafp_pkg::YAW_LO_IDX) yaw_lo_byte = b;
          else if (hunt_count == iafp_pkg::YAW_HI_IDX) yaw_hi_byte = b;
          frame_sum  = frame_sum + b;
          hunt_count = hunt_count + 4'd1;
        end
      end
      default: restart_hunt();
    endcase
  endtask

  // send one byte beat; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    parse_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // send a full 11-byte frame with the given yaw word
  task automatic send_frame(input logic [15:0] yaw, input bit rand_body,
                            input logic [7:0] fill, input bit good_sum);
    logic [7:0] b;
    logic [7:0] sum;
    int         i;
    sum = '0;
    for (i = 0; i < iafp_pkg::FRAME_BYTES - 1; i++) begin
      if (i == 0) b = iafp_pkg::HDR_FIRST;
      else if (i == 1) b = iafp_pkg::HDR_SECOND;
      else if (i == iafp_pkg::YAW_LO_IDX) b = yaw[7:0];
      else if (i == iafp_pkg::YAW_HI_IDX) b = yaw[15:8];
      else b = rand_body ? 8'($urandom) : fill;
      send_byte(b);
      sum = sum + b;
    end
    send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  // stop offering bytes until every frame result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (pending_angles.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // extremes: noise, a wrong second header that is itself 0x55, max yaw, bad checksum
  task automatic test_directed();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(iafp_pkg::HDR_FIRST);
    send_byte(iafp_pkg::HDR_FIRST);
    send_frame(16'hFFFF, 1'b0, 8'hFF, 1'b1);
    send_frame(16'h0000, 1'b0, 8'h00, 1'b0);
    drain_results();
  endtask

  // mostly well-formed frames with random content, plus broken headers and noise
  task automatic test_random_stream(input int n_bytes);
    int         stop_at;
    int         kind;
    int         i;
    logic [15:0] yaw;
    logic [7:0]  b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) tx_steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 15) == 0) rx_steady = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        case ($urandom_range(0, 7))
          0: yaw = 16'h0000;
          1: yaw = 16'hFFFF;
          2: yaw = 16'h8000;
          default: yaw = 16'($urandom);
        endcase
        send_frame(yaw, 1'b1, 8'h00, $urandom_range(0, 3) != 0);
      end else if (kind == 7) begin
        // first header followed by anything but the second header
        send_byte(iafp_pkg::HDR_FIRST);
        do b = 8'($urandom); while (b == iafp_pkg::HDR_SECOND);
        if ($urandom_range(0, 3) == 0) b = iafp_pkg::HDR_FIRST;
        send_byte(b);
      end else begin
        for (i = $urandom_range(1, 4); i > 0; i--) send_byte(8'($urandom));
      end
      if ($urandom_range(0, 60) == 0) drain_results();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // long output stall while frames keep arriving back to back
  task automatic test_backpressure();
    int i;
    rx_hold_req = 300;
    tx_steady   = 1'b1;
    for (i = 0; i < 12; i++) send_frame(16'($urandom), 1'b1, 8'h00, 1'b1);
    tx_steady = 1'b0;
    drain_results();
  endtask

  // a few frames, a full pause until all results are back, then more
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 3; i++) send_frame(16'($urandom), 1'b1, 8'h00, 1'($urandom_range(0, 1)));
    drain_results();
    for (i = 0; i < 3; i++) send_frame(16'($urandom), 1'b1, 8'h00, 1'b1);
    drain_results();
  endtask

  // result sink: random stall per beat, long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid && out_ch.ready));
    end
  end

  // compare each result beat with the oldest expected frame
  always @(posedge clk) begin
    angle_res_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result beat ok=%0b raw=%h deg=%h", $realtime,
                 out_ch.frame_ok, out_ch.yaw_raw, out_ch.yaw_deg_q8);
        mismatches++;
      end else begin
        exp_res = pending_angles.pop_front();
        if (out_ch.frame_ok !== exp_res.ok) begin
          $display("%0t: frame_ok expected %0b actual %0b", $realtime, exp_res.ok,
                   out_ch.frame_ok);
          mismatches++;
        end
        if (out_ch.yaw_raw !== exp_res.raw) begin
          $display("%0t: yaw_raw expected %h actual %h", $realtime, exp_res.raw,
                   out_ch.yaw_raw);
          mismatches++;
        end
        if (out_ch.yaw_deg_q8 !== exp_res.deg) begin
          $display("%0t: yaw_deg_q8 expected %h actual %h", $realtime, exp_res.deg,
                   out_ch.yaw_deg_q8);
          mismatches++;
        end
        if (exp_res.ok) good_frames++;
        else bad_frames++;
      end
    end
  end

  // input stall count under back-pressure
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
  end

  // main sequence
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    restart_hunt();
    yaw_lo_byte = '0;
    yaw_hi_byte = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_stream(800);
    test_backpressure();
    test_drain_pause();
    test_random_stream(700);

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes: %0d good frames and %0d bad-checksum frames", bytes_sent,
             good_frames, bad_frames);
    $display("input held off for %0d cycles by output back-pressure", in_stall_cycles);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", pending_angles.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
